// ----- design/adam_upd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_upd_pkg
// Shared widths, reset values, register codes and fixed-point helpers for the
// Adam weight update block.
// ----------------------------------------------------------------------------
package adam_upd_pkg;

  localparam int DEPTH   = 4096;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 24;
  localparam int PWR_W   = FRAC_W + 1;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [PWR_W-1:0] ONE_Q   = PWR_W'(1) << FRAC_W;
  localparam logic [63:0]      HALF_64 = 64'd1 << (FRAC_W - 1);

  // divider: 64-bit numerator, 37-bit divisor, 34 quotient bits
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 37;
  localparam int DIV_QW = 34;

  // square root: 32-bit input scaled by 2^32, 32-bit root
  localparam int SQ_IN_W  = 32;
  localparam int SQ_X_W   = 2 * SQ_IN_W;
  localparam int SQ_RT_W  = SQ_X_W / 2;
  localparam int SQ_REM_W = SQ_RT_W + 2;

  localparam logic [23:0] LR_RESET  = 24'd16777;
  localparam logic [23:0] B1_RESET  = 24'd15099494;
  localparam logic [23:0] B2_RESET  = 24'd16760439;
  localparam logic [31:0] EPS_RESET = 32'd43;
  localparam logic [23:0] WD_RESET  = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LR  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_EPS = 3'd3,
    REG_WD  = 3'd4
  } cfg_reg_t;

  localparam logic signed [63:0] SMAX_64 = 64'sd2147483647;
  localparam logic signed [63:0] SMIN_64 = -64'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SMAX_64) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SMIN_64) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // round to nearest on a shift by FRAC_W, ties away from zero
  function automatic logic signed [63:0] rnd_s24(input logic signed [63:0] x);
    logic [63:0] ux;
    logic [63:0] mag;
    logic [63:0] r;
    ux  = x;
    mag = x[63] ? (~ux + 64'd1) : ux;
    r   = (mag + HALF_64) >> FRAC_W;
    return x[63] ? $signed(~r + 64'd1) : $signed(r);
  endfunction

endpackage

// ----- design/adam_upd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_upd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable.
// ----------------------------------------------------------------------------
module adam_upd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/adam_upd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_upd_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// that does not fit in DIV_QW bits.
// ----------------------------------------------------------------------------
module adam_upd_div import adam_upd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo,
  output logic              ovf
);

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_QW-1:0] rest;
    logic [DIV_QW-1:0] q;
    logic [DIV_DW-1:0] d;
    logic              ovf;
  } dstage_t;

  dstage_t head;
  dstage_t st [DIV_QW];

  function automatic dstage_t div_step(input dstage_t p);
    dstage_t n;
    logic [DIV_DW:0] trial;
    logic            qbit;
    trial = {p.rem, p.rest[DIV_QW-1]};
    qbit  = (trial >= {1'b0, p.d});
    n     = p;
    n.rem = qbit ? DIV_DW'(trial - {1'b0, p.d}) : trial[DIV_DW-1:0];
    n.rest = p.rest << 1;
    n.q    = {p.q[DIV_QW-2:0], qbit};
    return n;
  endfunction

  always_comb begin
    head.rem  = DIV_DW'(num[DIV_NW-1:DIV_QW]);
    head.rest = num[DIV_QW-1:0];
    head.q    = '0;
    head.d    = den;
    head.ovf  = (DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(head);
      for (int i = 1; i < DIV_QW; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  assign quo = st[DIV_QW-1].q;
  assign ovf = st[DIV_QW-1].ovf;

endmodule

// ----- design/adam_upd_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_upd_sqrt
// Pipelined digit-by-digit integer square root of (value << 32), one root
// bit per stage, result rounded down.
// ----------------------------------------------------------------------------
module adam_upd_sqrt import adam_upd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_IN_W-1:0] value,
  output logic [SQ_RT_W-1:0] root
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_X_W-1:0]   rest;
    logic [SQ_RT_W-1:0]  rt;
  } sstage_t;

  sstage_t head;
  sstage_t st [SQ_RT_W];

  function automatic sstage_t sq_step(input sstage_t p);
    sstage_t n;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] t;
    trial = {p.rem, p.rest[SQ_X_W-1 -: 2]};
    t     = (SQ_REM_W+2)'({p.rt, 2'b01});
    n.rest = p.rest << 2;
    if (trial >= t) begin
      n.rem = SQ_REM_W'(trial - t);
      n.rt  = {p.rt[SQ_RT_W-2:0], 1'b1};
    end else begin
      n.rem = trial[SQ_REM_W-1:0];
      n.rt  = {p.rt[SQ_RT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    head.rem  = '0;
    head.rest = {value, {SQ_IN_W{1'b0}}};
    head.rt   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sq_step(head);
      for (int i = 1; i < SQ_RT_W; i++) begin
        st[i] <= sq_step(st[i-1]);
      end
    end
  end

  assign root = st[SQ_RT_W-1].rt;

endmodule

// ----- design/adam_optimizer_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Fixed-point Adam weight update with L2 decay, one weight element per
// transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_stall with element_index, gradient, weight
//   and last_of_step; results leave on result_valid/result_stall carrying
//   result_index, new_weight and step_done, one per item, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Throughput and depth:
//   One item per cycle while item_stall is low. The depth comes from two
//   34-stage dividers (bias correction, then the step size) and a 32-stage
//   square root; the moment memories are read and written back with
//   forwarding, so repeated indexes run at full rate.
// Reset:
//   rst clears the pipeline, restores the registers and sets both decay
//   powers to one. The moment memories are then cleared, one entry a cycle,
//   through all 4096 entries; item_stall is high during that pass.
// Back-pressure:
//   An output register plus one skid entry follow the pipeline. While
//   result_stall holds, one more result is absorbed; then item_stall rises
//   and the whole pipeline holds.
// ----------------------------------------------------------------------------
module adam_optimizer_update import adam_upd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] weight,
  input  logic                     last_of_step,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [DATA_W-1:0] new_weight,
  output logic                     step_done
);

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
    logic                     last;
  } base_t;

  typedef struct packed {
    base_t                    b;
    logic [PWR_W-1:0]         bc1;
    logic [PWR_W-1:0]         bc2;
    logic signed [DATA_W-1:0] g;
    logic signed [56:0]       pwd;
  } s1_t;

  typedef struct packed {
    base_t                    b;
    logic [PWR_W-1:0]         bc1;
    logic [PWR_W-1:0]         bc2;
    logic signed [DATA_W-1:0] gd;
  } s2_t;

  typedef struct packed {
    base_t              b;
    logic [PWR_W-1:0]   bc1;
    logic [PWR_W-1:0]   bc2;
    logic [63:0]        sq;
    logic signed [57:0] pm;
  } s3_t;

  typedef struct packed {
    base_t              b;
    logic [PWR_W-1:0]   bc1;
    logic [PWR_W-1:0]   bc2;
    logic [DATA_W-1:0]  gsq;
    logic signed [57:0] pm;
  } s4_t;

  typedef struct packed {
    base_t              b;
    logic [PWR_W-1:0]   bc1;
    logic [PWR_W-1:0]   bc2;
    logic signed [57:0] pm;
    logic [56:0]        pv;
  } s5_t;

  typedef struct packed {
    base_t                    b;
    logic [PWR_W-1:0]         bc1;
    logic [PWR_W-1:0]         bc2;
    logic signed [DATA_W-1:0] m;
    logic [DATA_W-1:0]        v;
  } s6_t;

  typedef struct packed {
    base_t b;
    logic  neg;
  } l1_t;

  typedef struct packed {
    base_t             b;
    logic              neg;
    logic [DATA_W-1:0] mh;
    logic [DATA_W-1:0] vh;
  } q_t;

  typedef struct packed {
    base_t       b;
    logic        neg;
    logic [55:0] prod;
  } l2_t;

  typedef struct packed {
    base_t             b;
    logic              neg;
    logic [55:0]       prod;
    logic [DIV_DW-1:0] den;
  } d_t;

  localparam logic [DIV_QW-1:0] DELTA_CAP = DIV_QW'(1) << 33;

  // configuration
  logic [23:0] learning_rate;
  logic [23:0] first_decay;
  logic [23:0] second_decay;
  logic [31:0] epsilon;
  logic [23:0] l2_factor;

  logic [PWR_W-1:0] first_power;
  logic [PWR_W-1:0] second_power;

  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  logic adv;
  logic accept;

  s1_t s1;
  s2_t s2;
  s3_t s3;
  s4_t s4;
  s5_t s5;
  s6_t s6;
  q_t  qs;
  d_t  ds;
  base_t fs;
  logic signed [DATA_W-1:0] fs_nw;

  l1_t l1 [DIV_QW];
  l2_t l2 [SQ_RT_W];
  l1_t l3 [DIV_QW];

  logic                     s7_valid;
  logic [IDX_W-1:0]         s7_idx;
  logic signed [DATA_W-1:0] s7_m;
  logic [DATA_W-1:0]        s7_v;

  logic                     skid_valid;
  logic [IDX_W-1:0]         skid_idx;
  logic signed [DATA_W-1:0] skid_nw;
  logic                     skid_last;

  // ---------------------------------------------------------------- control
  assign adv        = !skid_valid;
  assign item_stall = clearing || skid_valid;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      first_decay   <= B1_RESET;
      second_decay  <= B2_RESET;
      epsilon       <= EPS_RESET;
      l2_factor     <= WD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LR:  learning_rate <= cfg_data[23:0];
        REG_B1:  first_decay   <= cfg_data[23:0];
        REG_B2:  second_decay  <= cfg_data[23:0];
        REG_EPS: epsilon       <= cfg_data;
        REG_WD:  l2_factor     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- decay powers
  logic [49:0]      pp1;
  logic [49:0]      pp2;
  logic [PWR_W-1:0] p1n;
  logic [PWR_W-1:0] p2n;

  assign pp1 = 50'(first_power) * 50'(first_decay) + 50'(HALF_64);
  assign pp2 = 50'(second_power) * 50'(second_decay) + 50'(HALF_64);
  assign p1n = pp1[FRAC_W +: PWR_W];
  assign p2n = pp2[FRAC_W +: PWR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_power  <= ONE_Q;
      second_power <= ONE_Q;
    end else if (accept && last_of_step) begin
      first_power  <= p1n;
      second_power <= p2n;
    end
  end

  // ------------------------------------------------------ stage arithmetic
  logic [PWR_W-1:0]         one_m_b1;
  logic [PWR_W-1:0]         one_m_b2;
  logic signed [56:0]       pwd_in;
  logic signed [63:0]       gd_wide;
  logic signed [DATA_W-1:0] gd;
  logic signed [63:0]       sq;
  logic signed [57:0]       pm;
  logic [63:0]              sq_r;
  logic [DATA_W-1:0]        gsq;
  logic [56:0]              pv;

  assign one_m_b1 = ONE_Q - PWR_W'(first_decay);
  assign one_m_b2 = ONE_Q - PWR_W'(second_decay);
  assign pwd_in   = $signed({1'b0, l2_factor}) * weight;
  assign gd_wide  = $signed({{32{s1.g[DATA_W-1]}}, s1.g})
                  + rnd_s24($signed({{7{s1.pwd[56]}}, s1.pwd}));
  assign gd       = sat_s32(gd_wide);
  assign sq       = s2.gd * s2.gd;
  assign pm       = $signed({1'b0, one_m_b1}) * s2.gd;
  assign sq_r     = (s3.sq + HALF_64) >> FRAC_W;
  assign gsq      = (sq_r[63:DATA_W] != '0) ? '1 : sq_r[DATA_W-1:0];
  assign pv       = 57'(one_m_b2) * 57'(s4.gsq);

  // moment memories
  logic signed [DATA_W-1:0] ram_m;
  logic [DATA_W-1:0]        ram_v;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [DATA_W-1:0]        wr_m;
  logic [DATA_W-1:0]        wr_v;

  assign mem_we    = clearing || (s6.b.valid && adv);
  assign mem_waddr = clearing ? clr_addr : s6.b.idx;
  assign wr_m      = clearing ? '0 : s6.m;
  assign wr_v      = clearing ? '0 : s6.v;

  adam_upd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_first_moment (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_m),
    .re    (adv),
    .raddr (s4.b.idx),
    .rdata (ram_m)
  );

  adam_upd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_second_moment (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_v),
    .re    (adv),
    .raddr (s4.b.idx),
    .rdata (ram_v)
  );

  // forward results not yet visible in the memory read
  logic signed [DATA_W-1:0] m_old;
  logic [DATA_W-1:0]        v_old;
  logic signed [58:0]       m_sum;
  logic [57:0]              v_sum;
  logic [33:0]              v_sh;
  logic signed [DATA_W-1:0] m_new;
  logic [DATA_W-1:0]        v_new;

  always_comb begin
    if (s6.b.valid && s6.b.idx == s5.b.idx) begin
      m_old = s6.m;
      v_old = s6.v;
    end else if (s7_valid && s7_idx == s5.b.idx) begin
      m_old = s7_m;
      v_old = s7_v;
    end else begin
      m_old = ram_m;
      v_old = ram_v;
    end
  end

  assign m_sum = $signed({1'b0, first_decay}) * m_old + s5.pm;
  assign m_new = sat_s32(rnd_s24($signed({{5{m_sum[58]}}, m_sum})));
  assign v_sum = 58'(second_decay) * 58'(v_old) + 58'(s5.pv) + 58'(HALF_64);
  assign v_sh  = v_sum[FRAC_W +: 34];
  assign v_new = (v_sh[33:32] != 2'b00) ? '1 : v_sh[DATA_W-1:0];

  // bias correction dividers
  logic [DATA_W-1:0] m_mag;
  logic [DIV_NW-1:0] num_a;
  logic [DIV_NW-1:0] num_b;
  logic [DIV_QW-1:0] quo_a;
  logic [DIV_QW-1:0] quo_b;
  logic              ovf_a;
  logic              ovf_b;

  assign m_mag = s6.m[DATA_W-1] ? (~s6.m + DATA_W'(1)) : s6.m;
  assign num_a = DIV_NW'({m_mag, {FRAC_W{1'b0}}}) + DIV_NW'(s6.bc1 >> 1);
  assign num_b = DIV_NW'({s6.v, {FRAC_W{1'b0}}}) + DIV_NW'(s6.bc2 >> 1);

  adam_upd_div u_div_mean (
    .clk (clk),
    .en  (adv),
    .num (num_a),
    .den (DIV_DW'(s6.bc1)),
    .quo (quo_a),
    .ovf (ovf_a)
  );

  adam_upd_div u_div_var (
    .clk (clk),
    .en  (adv),
    .num (num_b),
    .den (DIV_DW'(s6.bc2)),
    .quo (quo_b),
    .ovf (ovf_b)
  );

  l1_t               l1_out;
  logic [DATA_W-1:0] cap_a;
  logic [DATA_W-1:0] mh_sat;
  logic [DATA_W-1:0] vh_sat;

  assign l1_out = l1[DIV_QW-1];
  assign cap_a  = l1_out.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mh_sat = (ovf_a || quo_a > DIV_QW'(cap_a)) ? cap_a : quo_a[DATA_W-1:0];
  assign vh_sat = (ovf_b || quo_b[DIV_QW-1:DATA_W] != '0) ? '1 : quo_b[DATA_W-1:0];

  // root of the corrected variance
  logic [SQ_RT_W-1:0] root;
  logic [55:0]        lr_prod;

  adam_upd_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .value (qs.vh),
    .root  (root)
  );

  assign lr_prod = 56'(learning_rate) * 56'(qs.mh);

  l2_t               l2_out;
  logic [DIV_DW-1:0] den_sum;
  logic [DIV_DW-1:0] den;

  assign l2_out  = l2[SQ_RT_W-1];
  assign den_sum = DIV_DW'({root, 4'b0000}) + DIV_DW'(epsilon);
  assign den     = (den_sum == '0) ? DIV_DW'(1) : den_sum;

  // step size division
  logic [DIV_NW-1:0] num_c;
  logic [DIV_QW-1:0] quo_c;
  logic              ovf_c;

  assign num_c = {ds.prod, 8'b0000_0000} + DIV_NW'(ds.den >> 1);

  adam_upd_div u_div_step (
    .clk (clk),
    .en  (adv),
    .num (num_c),
    .den (ds.den),
    .quo (quo_c),
    .ovf (ovf_c)
  );

  l1_t                l3_out;
  logic [DIV_QW-1:0]  dmag;
  logic signed [63:0] delta;
  logic signed [63:0] nw_wide;

  assign l3_out  = l3[DIV_QW-1];
  assign dmag    = (ovf_c || quo_c > DELTA_CAP) ? DELTA_CAP : quo_c;
  assign delta   = l3_out.neg ? -$signed(64'(dmag)) : $signed(64'(dmag));
  assign nw_wide = $signed({{32{l3_out.b.w[DATA_W-1]}}, l3_out.b.w}) - delta;

  // --------------------------------------------------------- pipeline regs
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.b.valid <= 1'b0;
      s2.b.valid <= 1'b0;
      s3.b.valid <= 1'b0;
      s4.b.valid <= 1'b0;
      s5.b.valid <= 1'b0;
      s6.b.valid <= 1'b0;
      s7_valid   <= 1'b0;
      qs.b.valid <= 1'b0;
      ds.b.valid <= 1'b0;
      fs.valid   <= 1'b0;
      for (int i = 0; i < DIV_QW; i++) begin
        l1[i].b.valid <= 1'b0;
        l3[i].b.valid <= 1'b0;
      end
      for (int i = 0; i < SQ_RT_W; i++) begin
        l2[i].b.valid <= 1'b0;
      end
    end else if (adv) begin
      s1.b.valid <= accept;
      s1.b.idx   <= element_index;
      s1.b.w     <= weight;
      s1.b.last  <= last_of_step;
      s1.bc1     <= ONE_Q - p1n;
      s1.bc2     <= ONE_Q - p2n;
      s1.g       <= gradient;
      s1.pwd     <= pwd_in;

      s2.b   <= s1.b;
      s2.bc1 <= s1.bc1;
      s2.bc2 <= s1.bc2;
      s2.gd  <= gd;

      s3.b   <= s2.b;
      s3.bc1 <= s2.bc1;
      s3.bc2 <= s2.bc2;
      s3.sq  <= sq;
      s3.pm  <= pm;

      s4.b   <= s3.b;
      s4.bc1 <= s3.bc1;
      s4.bc2 <= s3.bc2;
      s4.gsq <= gsq;
      s4.pm  <= s3.pm;

      s5.b   <= s4.b;
      s5.bc1 <= s4.bc1;
      s5.bc2 <= s4.bc2;
      s5.pm  <= s4.pm;
      s5.pv  <= pv;

      s6.b   <= s5.b;
      s6.bc1 <= s5.bc1;
      s6.bc2 <= s5.bc2;
      s6.m   <= m_new;
      s6.v   <= v_new;

      s7_valid <= s6.b.valid;
      s7_idx   <= s6.b.idx;
      s7_m     <= s6.m;
      s7_v     <= s6.v;

      l1[0].b   <= s6.b;
      l1[0].neg <= s6.m[DATA_W-1];
      for (int i = 1; i < DIV_QW; i++) begin
        l1[i] <= l1[i-1];
      end

      qs.b   <= l1_out.b;
      qs.neg <= l1_out.neg;
      qs.mh  <= mh_sat;
      qs.vh  <= vh_sat;

      l2[0].b    <= qs.b;
      l2[0].neg  <= qs.neg;
      l2[0].prod <= lr_prod;
      for (int i = 1; i < SQ_RT_W; i++) begin
        l2[i] <= l2[i-1];
      end

      ds.b    <= l2_out.b;
      ds.neg  <= l2_out.neg;
      ds.prod <= l2_out.prod;
      ds.den  <= den;

      l3[0].b   <= ds.b;
      l3[0].neg <= ds.neg;
      for (int i = 1; i < DIV_QW; i++) begin
        l3[i] <= l3[i-1];
      end

      fs    <= l3_out.b;
      fs_nw <= sat_s32(nw_wide);
    end
  end

  // ---------------------------------------------------- output and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        result_index <= skid_idx;
        new_weight   <= skid_nw;
        step_done    <= skid_last;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= fs.valid;
        result_index <= fs.idx;
        new_weight   <= fs_nw;
        step_done    <= fs.last;
      end
    end else if (fs.valid && adv) begin
      // hold the finished result while the output waits
      skid_valid <= 1'b1;
      skid_idx   <= fs.idx;
      skid_nw    <= fs_nw;
      skid_last  <= fs.last;
    end
  end

  // ------------------------------------------------------------ assertions
  a_fwd_track: assert property (@(posedge clk) disable iff (rst)
    (adv && s6.b.valid) |=> (s7_valid && s7_idx == $past(s6.b.idx)))
    else $error("write-back forwarding register lost an entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid filled while output was free");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    (first_power <= ONE_Q) && (second_power <= ONE_Q))
    else $error("decay power above one");

  a_bc_nonzero: assert property (@(posedge clk) disable iff (rst)
    s6.b.valid |-> (s6.bc1 != '0 && s6.bc2 != '0))
    else $error("zero bias correction reached divider");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1.b.valid && !result_valid && !skid_valid))
    else $error("item in flight during memory clear");

endmodule

// ----- sim/adam_update_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_update_checker
// Watches the item, result and configuration ports of the Adam update block.
// Keeps its own copy of the moment memories, decay powers and registers,
// predicts each weight update and compares it with the results in order.
// ----------------------------------------------------------------------------
module adam_update_checker import adam_upd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] weight,
  input  logic                     last_of_step,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic [IDX_W-1:0]         result_index,
  input  logic signed [DATA_W-1:0] new_weight,
  input  logic                     step_done,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] weight;
    logic                     done;
  } update_t;

  localparam longint UNIT     = longint'(1) << FRAC_W;
  localparam longint HALF     = longint'(1) << (FRAC_W - 1);
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;

  update_t                  updates_due[$];
  logic signed [DATA_W-1:0] mean_mem[DEPTH];
  logic [DATA_W-1:0]        var_mem[DEPTH];
  logic [PWR_W-1:0]         mean_pow, var_pow;
  logic [23:0]              lr, beta1, beta2, decay;
  logic [31:0]              eps;

  assign pending = updates_due.size();

  function automatic longint clamp_s(longint x);
    return x > S32_MAX ? S32_MAX : (x < S32_MIN ? S32_MIN : x);
  endfunction

  function automatic longint unsigned clamp_u(longint unsigned x);
    return x > U32_MAX ? U32_MAX : x;
  endfunction

  // round half away from zero while dropping the fraction bits
  function automatic longint round_frac(longint x);
    longint unsigned mag;
    mag = x < 0 ? longint'(-x) : x;
    mag = (mag + HALF) >> FRAC_W;
    return x < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    mag = num < 0 ? longint'(-num) : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bit_pos;
    res = 0;
    bit_pos = longint'(1) << 62;
    while (bit_pos > x) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (x >= res + bit_pos) begin
        x -= res + bit_pos;
        res = (res >> 1) + bit_pos;
      end else begin
        res >>= 1;
      end
      bit_pos >>= 2;
    end
    return res;
  endfunction

  task automatic predict_update();
    longint g, w, gd, m, mh, delta;
    longint unsigned gsq, v, vh, root, den, mag, p1n, p2n, bc1, bc2;
    update_t u;
    g  = gradient;
    w  = weight;
    gd = clamp_s(g + round_frac(longint'(decay) * w));
    m  = clamp_s(round_frac(longint'(beta1) * mean_mem[element_index] +
                            (UNIT - longint'(beta1)) * gd));
    gsq = clamp_u(round_frac(gd * gd));
    v = clamp_u((longint'(beta2) * var_mem[element_index] +
                 (UNIT - beta2) * gsq + HALF) >> FRAC_W);
    mean_mem[element_index] = m[DATA_W-1:0];
    var_mem[element_index]  = v[DATA_W-1:0];
    p1n = (longint'(mean_pow) * beta1 + HALF) >> FRAC_W;
    p2n = (longint'(var_pow) * beta2 + HALF) >> FRAC_W;
    bc1 = UNIT - p1n;
    bc2 = UNIT - p2n;
    mh = clamp_s(round_div(m * UNIT, bc1));
    vh = clamp_u((v * UNIT + bc2 / 2) / bc2);
    root = int_sqrt(vh << 32);
    den = (root << 4) + eps;
    // zero denominator: fall back to one LSB
    if (den == 0) den = 1;
    mag = (longint'(lr) * (mh < 0 ? -mh : mh)) << 8;
    mag = (mag + den / 2) / den;
    if (mag > (longint'(1) << 33)) mag = longint'(1) << 33;
    delta = mh < 0 ? -longint'(mag) : longint'(mag);
    if (last_of_step) begin
      mean_pow = p1n[PWR_W-1:0];
      var_pow  = p2n[PWR_W-1:0];
    end
    u.index  = element_index;
    u.weight = clamp_s(w - delta);
    u.done   = last_of_step;
    updates_due = {updates_due, u};
  endtask

  always @(posedge clk) begin
    update_t u;
    if (rst) begin
      lr = LR_RESET; beta1 = B1_RESET; beta2 = B2_RESET;
      eps = EPS_RESET; decay = WD_RESET;
      mean_pow = ONE_Q; var_pow = ONE_Q;
      for (int i = 0; i < DEPTH; i++) begin
        mean_mem[i] = '0;
        var_mem[i]  = '0;
      end
      updates_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LR:  lr    = cfg_data[23:0];
          REG_B1:  beta1 = cfg_data[23:0];
          REG_B2:  beta2 = cfg_data[23:0];
          REG_EPS: eps   = cfg_data;
          REG_WD:  decay = cfg_data[23:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) predict_update();
      if (result_valid && !result_stall) begin
        if (updates_due.size() == 0) begin
          $error("result with no update pending: index %0d", result_index);
          fail_count++;
        end else begin
          u = updates_due.pop_front();
          if (result_index !== u.index) begin
            $error("result_index expected %0d got %0d", u.index, result_index);
            fail_count++;
          end
          if (new_weight !== u.weight) begin
            $error("new_weight expected %0d got %0d", u.weight, new_weight);
            fail_count++;
          end
          if (step_done !== u.done) begin
            $error("step_done expected %0d got %0d", u.done, step_done);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the Adam update block with directed and random weight elements over
// several register settings, with random stalls on both sides, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench import adam_upd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                     clk, rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     item_valid, item_stall;
  logic [IDX_W-1:0]         element_index;
  logic signed [DATA_W-1:0] gradient, weight;
  logic                     last_of_step;
  logic                     result_valid, result_stall;
  logic [IDX_W-1:0]         result_index;
  logic signed [DATA_W-1:0] new_weight;
  logic                     step_done;
  int                       fail_count, pending;
  bit                       quiet, hold_req, run_done;

  adam_optimizer_update DUT (.*);

  adam_update_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    int hold;
    bit hold_seen;
    hold = 0;
    hold_seen = 0;
    result_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold = 400;
        hold_seen = 1;
      end
      if (hold > 0) begin
        result_stall <= 1;
        hold--;
      end else if (quiet) begin
        result_stall <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 14);
        result_stall <= 1;
        hold--;
      end else begin
        result_stall <= 0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
        idle = 0;
      else if (!run_done)
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t r, logic [31:0] value);
    cfg_we    <= 1;
    cfg_index <= r;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic send_element(int idx, int g, int w, bit last);
    item_valid    <= 1;
    element_index <= IDX_W'(idx);
    gradient      <= g;
    weight        <= w;
    last_of_step  <= last;
    while (item_stall) @(negedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic random_element();
    int idx, g, w;
    idx = $urandom_range(0, 9) < 7 ? $urandom_range(0, 31) : $urandom_range(0, 4095);
    case ($urandom_range(0, 4))
      0, 1: begin g = $signed($urandom_range(0, 1 << 25)) - (1 << 24); end
      2: begin g = $signed($urandom_range(0, 1 << 14)) - (1 << 13); end
      3: begin g = $urandom(); end
      default: begin g = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000; end
    endcase
    w = $urandom_range(0, 3) == 0 ? $urandom()
                                  : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    send_element(idx, g, w, $urandom_range(0, 15) == 0);
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    item_valid = 0; element_index = '0; gradient = '0; weight = '0;
    last_of_step = 0; quiet = 0; hold_req = 0; run_done = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings: extremes of the fields, repeated index
    send_element(0, 0, 0, 0);
    send_element(4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_element(4095, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_element(5, 1 << 24, 1 << 23, 0);
    send_element(5, 1 << 24, 1 << 23, 0);
    send_element(5, -(1 << 22), 0, 1);
    send_element(5, 1 << 20, -(1 << 24), 1);
    item_valid <= 0;
    settle();

    // extremes: zero denominator, full decay, zero moment decay
    write_reg(REG_LR, 32'hFF_FFFF);
    write_reg(REG_B1, 32'h0);
    write_reg(REG_B2, 32'hFF_FFFF);
    write_reg(REG_EPS, 32'h0);
    write_reg(REG_WD, 32'hFF_FFFF);
    cfg_we <= 0;
    send_element(100, 1, 0, 0);
    send_element(101, -1, 0, 0);
    send_element(102, 0, 0, 1);
    send_element(4000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_element(4001, 32'sh8000_0000, 32'sh8000_0000, 1);
    send_element(4001, 1 << 24, -(1 << 24), 0);
    item_valid <= 0;
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_LR, 32'(LR_RESET)); write_reg(REG_B1, 32'(B1_RESET));
          write_reg(REG_B2, 32'(B2_RESET)); write_reg(REG_EPS, EPS_RESET);
          write_reg(REG_WD, 32'(WD_RESET));
        end
        1: begin
          write_reg(REG_EPS, 32'hFFFF_FFFF); write_reg(REG_B1, 32'hFF_FFFF);
          write_reg(REG_WD, 32'h0);
        end
        default: begin
          write_reg(REG_LR, $urandom_range(0, 24'hFF_FFFF));
          write_reg(REG_B1, $urandom_range(0, 24'hFF_FFFF));
          write_reg(REG_B2, $urandom_range(0, 24'hFF_FFFF));
          write_reg(REG_EPS, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4096));
          write_reg(REG_WD, $urandom_range(0, 1) ? 0 : $urandom_range(0, 24'hFF_FFFF));
        end
      endcase
      cfg_we <= 0;
      if (phase == 4) quiet = 1;
      for (int n = 0; n < 200; n++) begin
        if (phase == 2 && n == 20) hold_req = 1;
        random_element();
      end
      item_valid <= 0;
      settle();
    end

    run_done = 1;
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/adam_upd_pkg.sv
design/adam_upd_ram.sv
design/adam_upd_div.sv
design/adam_upd_sqrt.sv
design/adam_optimizer_update.sv
sim/adam_update_checker.sv
sim/testbench.sv
